>>> sv/tkdp_pkg.sv
// ----------------------------------------------------------------------------
// tkdp_pkg
// shared types, constants and codes of the top-k dot-product search unit
// ----------------------------------------------------------------------------
package tkdp_pkg;

   localparam int MAX_RESULTS_DEF = 16;
   localparam int MAX_LENGTH_DEF  = 1024;
   localparam int MAX_VECTORS_DEF = 65536;

   localparam int SCORE_W = 42;
   localparam int ID_W    = 16;
   localparam int ELEM_W  = 16;
   localparam int COUNT_W = 5;
   localparam int LEN_W   = 11;

   localparam logic [4:0]  COUNT_RESET = 5'd10;
   localparam logic [10:0] LEN_RESET   = 11'd128;

   // func codes
   localparam logic [1:0] FUNC_QUERY  = 2'd0;
   localparam logic [1:0] FUNC_VECTOR = 2'd1;
   localparam logic [1:0] FUNC_FINISH = 2'd2;

   // register indexes
   localparam logic REG_COUNT  = 1'b0;
   localparam logic REG_LENGTH = 1'b1;

   // controller to datapath commands
   typedef struct packed {
      logic query_wr;     // write query element
      logic mac;          // multiply stage 1 (read query done, multiply)
      logic acc;          // add product into accumulator
      logic vec_end;      // vector finished: insert if allowed
      logic vec_skip;
      logic finish;       // clear list and counters
      logic emit;         // present list entry
   } cmd_type;

   // datapath status
   typedef struct packed {
      logic list_empty;
      logic emit_last;
   } status_type;

endpackage

>>> sv/tkdp_ram.sv
// ----------------------------------------------------------------------------
// tkdp_ram
// generic ram with one write port, one read port and registered read
// ----------------------------------------------------------------------------
module tkdp_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

>>> sv/tkdp_datapath.sv
// ----------------------------------------------------------------------------
// tkdp_datapath
// query store, multiply-accumulate and sorted top list with shift-insert
// ----------------------------------------------------------------------------
module tkdp_datapath #(
   parameter int MAX_RESULTS = tkdp_pkg::MAX_RESULTS_DEF,
   parameter int MAX_LENGTH  = tkdp_pkg::MAX_LENGTH_DEF,
   parameter int MAX_VECTORS = tkdp_pkg::MAX_VECTORS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  tkdp_pkg::cmd_type                  cmd,
   input  logic signed [tkdp_pkg::ELEM_W-1:0] elem,
   input  logic [$clog2(MAX_LENGTH)-1:0]      query_addr,
   input  logic [$clog2(MAX_LENGTH)-1:0]      read_addr,
   input  logic                               read_ok,
   input  logic [$clog2(MAX_RESULTS+1)-1:0]   keep,
   output tkdp_pkg::status_type               status,
   output logic [tkdp_pkg::ID_W-1:0]          emit_id,
   output logic [tkdp_pkg::SCORE_W-1:0]       emit_score
);

   localparam int AW  = (MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1;
   localparam int KW  = $clog2(MAX_RESULTS+1);
   localparam int VW  = $clog2(MAX_VECTORS+1);
   localparam int SW  = tkdp_pkg::SCORE_W;
   localparam int IW  = tkdp_pkg::ID_W;

   logic signed [tkdp_pkg::ELEM_W-1:0] q_rd;
   logic signed [tkdp_pkg::ELEM_W-1:0] elem_ff;
   logic                               read_ok_ff;
   logic signed [31:0]                 prod_ff, prod_in;
   logic signed [SW-1:0]               acc_ff, acc_in;
   logic [VW-1:0]                      vid_ff, vid_in;
   logic signed [SW-1:0]               score_ff [MAX_RESULTS];
   logic [IW-1:0]                      id_ff    [MAX_RESULTS];
   logic [KW-1:0]                      fill_ff, fill_in;
   logic [KW-1:0]                      rd_ff, rd_in;
   logic [KW-1:0]                      used;
   logic [MAX_RESULTS-1:0]             ahead;
   logic signed [SW-1:0]               new_score;
   logic                               do_insert;

   // query memory
   tkdp_ram #(.WIDTH(tkdp_pkg::ELEM_W), .DEPTH(MAX_LENGTH)) u_query (
      .clock   (clock),
      .wr_en   (cmd.query_wr),
      .wr_addr (query_addr[AW-1:0]),
      .wr_data (elem),
      .rd_addr (read_addr[AW-1:0]),
      .rd_data (q_rd)
   );

   // element held alongside the query read
   always_ff @(posedge clock) begin
      elem_ff    <= elem;
      read_ok_ff <= read_ok;
      prod_ff    <= prod_in;
   end

   // multiply stage
   assign prod_in = read_ok_ff ? 32'(q_rd * elem_ff) : 32'sd0;

   // accumulator and score of the finished vector
   assign new_score = acc_ff + SW'(prod_ff);

   always_comb begin
      acc_in = acc_ff;
      if (cmd.acc) begin
         acc_in = cmd.vec_end ? '0 : new_score;
      end
      if (cmd.finish) begin
         acc_in = '0;
      end
   end

   // vector id counter, saturating at capacity
   always_comb begin
      vid_in = vid_ff;
      if (cmd.vec_end && vid_ff < VW'(MAX_VECTORS)) begin
         vid_in = vid_ff + 1'b1;
      end
      if (cmd.finish) begin
         vid_in = '0;
      end
   end

   // occupied entries limited by the count register
   assign used = (fill_ff < keep) ? fill_ff : keep;

   // rank comparison against each list entry
   always_comb begin
      for (int i = 0; i < MAX_RESULTS; i++) begin
         ahead[i] = (KW'(i) < used) &&
                    ((new_score > score_ff[i]) ||
                     (new_score == score_ff[i] && IW'(vid_ff) < id_ff[i]));
      end
   end

   assign do_insert = cmd.vec_end && !cmd.vec_skip && vid_ff < VW'(MAX_VECTORS) &&
                      (used < keep || ahead[0] || (used != '0 && ahead[KW'(used)-1]) ||
                       ahead != '0);

   // fill count, left alone by a skipped or out-of-capacity vector
   always_comb begin
      fill_in = fill_ff;
      if (cmd.vec_end && !cmd.vec_skip && vid_ff < VW'(MAX_VECTORS)) begin
         fill_in = used;
         if (do_insert && used != keep) begin
            fill_in = used + 1'b1;
         end
      end
      if (cmd.finish) begin
         fill_in = '0;
      end
   end

   // parallel shift-insert into the sorted list
   always_ff @(posedge clock) begin
      if (do_insert) begin
         for (int i = 0; i < MAX_RESULTS; i++) begin
            if (ahead[i]) begin
               if (i == 0 || !ahead[i-1]) begin
                  score_ff[i] <= new_score;
                  id_ff[i]    <= IW'(vid_ff);
               end else begin
                  score_ff[i] <= score_ff[i-1];
                  id_ff[i]    <= id_ff[i-1];
               end
            end else if (KW'(i) == used && used < keep) begin
               if (i == 0) begin
                  score_ff[i] <= new_score;
                  id_ff[i]    <= IW'(vid_ff);
               end else if (ahead[i-1]) begin
                  score_ff[i] <= score_ff[i-1];
                  id_ff[i]    <= id_ff[i-1];
               end else begin
                  score_ff[i] <= new_score;
                  id_ff[i]    <= IW'(vid_ff);
               end
            end
         end
      end
   end

   // emit read pointer
   always_comb begin
      rd_in = rd_ff;
      if (cmd.emit) begin
         rd_in = rd_ff + 1'b1;
      end
      if (cmd.finish) begin
         rd_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff  <= '0;
         vid_ff  <= '0;
         fill_ff <= '0;
         rd_ff   <= '0;
      end else begin
         acc_ff  <= acc_in;
         vid_ff  <= vid_in;
         fill_ff <= fill_in;
         rd_ff   <= rd_in;
      end
   end

   assign status.list_empty = (used == '0);
   assign status.emit_last  = (rd_ff + 1'b1 >= used);
   assign emit_id    = id_ff[rd_ff[$clog2(MAX_RESULTS > 1 ? MAX_RESULTS : 2)-1:0]];
   assign emit_score = score_ff[rd_ff[$clog2(MAX_RESULTS > 1 ? MAX_RESULTS : 2)-1:0]];

   // list never overflows its capacity
   assert property (@(posedge clock) disable iff (reset) fill_ff <= KW'(MAX_RESULTS))
      else $error("fill above capacity");
   // finish clears the fill count
   assert property (@(posedge clock) disable iff (reset) cmd.finish |=> fill_ff == '0)
      else $error("finish did not clear list");
   // the accumulator restarts after a vector ends
   assert property (@(posedge clock) disable iff (reset)
      (cmd.acc && cmd.vec_end) |=> acc_ff == '0)
      else $error("accumulator not cleared");

endmodule

>>> sv/tkdp_ctrl.sv
// ----------------------------------------------------------------------------
// tkdp_ctrl
// controller: element sequencing, vector end, finish and result emission
// ----------------------------------------------------------------------------
module tkdp_ctrl #(
   parameter int MAX_RESULTS = tkdp_pkg::MAX_RESULTS_DEF,
   parameter int MAX_LENGTH  = tkdp_pkg::MAX_LENGTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [1:0]                     func,
   input  logic                           skip,
   input  logic [tkdp_pkg::COUNT_W-1:0]   count_reg,
   input  logic [tkdp_pkg::LEN_W-1:0]     len_reg,
   input  tkdp_pkg::status_type           status,
   output tkdp_pkg::cmd_type              cmd,
   output logic [$clog2(MAX_LENGTH)-1:0]  query_addr,
   output logic [$clog2(MAX_LENGTH)-1:0]  read_addr,
   output logic                           read_ok,
   output logic [$clog2(MAX_RESULTS+1)-1:0] keep,
   output logic                           busy,
   output logic                           strobe,
   output logic                           found,
   output logic                           last
);

   localparam int AW = $clog2(MAX_LENGTH);
   localparam int PW = $clog2(MAX_LENGTH + 1) > 11 ? $clog2(MAX_LENGTH + 1) : 11;
   localparam int KW = $clog2(MAX_RESULTS+1);

   localparam logic [1:0] ST_RUN   = 2'd0;
   localparam logic [1:0] ST_DRAIN = 2'd1;
   localparam logic [1:0] ST_EMIT  = 2'd2;

   logic [1:0]    state_ff, state_in;
   logic [PW-1:0] qpos_ff, qpos_in, epos_ff, epos_in, len, qp;
   logic [1:0]    acc_pipe_ff, acc_pipe_in;
   logic [1:0]    end_pipe_ff, end_pipe_in;
   logic [1:0]    skip_pipe_ff, skip_pipe_in;
   logic          take, end_now;

   // effective length and count
   always_comb begin
      len = (len_reg == '0) ? PW'(1) : PW'(len_reg);
      if (len > PW'(MAX_LENGTH)) len = PW'(MAX_LENGTH);
      keep = (count_reg == '0) ? KW'(1) :
             ((32'(count_reg) > MAX_RESULTS) ? KW'(MAX_RESULTS) : KW'(count_reg));
   end

   assign take    = start && !busy;
   assign busy    = (state_ff != ST_RUN);
   assign qp      = (qpos_ff >= len) ? '0 : qpos_ff;
   assign end_now = (epos_ff + 1'b1 >= len);

   // positions
   always_comb begin
      qpos_in = qpos_ff;
      epos_in = epos_ff;
      if (take && func == tkdp_pkg::FUNC_QUERY) begin
         qpos_in = (qp + 1'b1 >= len) ? '0 : qp + 1'b1;
      end
      if (take && func == tkdp_pkg::FUNC_VECTOR) begin
         epos_in = end_now ? '0 : epos_ff + 1'b1;
      end
      if (take && func == tkdp_pkg::FUNC_FINISH) begin
         qpos_in = '0;
         epos_in = '0;
      end
   end

   assign query_addr = qp[AW-1:0];
   assign read_addr  = epos_ff[AW-1:0];
   assign read_ok    = epos_ff < PW'(MAX_LENGTH);

   // mac pipeline: read, multiply, accumulate
   assign acc_pipe_in  = {acc_pipe_ff[0], take && func == tkdp_pkg::FUNC_VECTOR};
   assign end_pipe_in  = {end_pipe_ff[0], take && func == tkdp_pkg::FUNC_VECTOR && end_now};
   assign skip_pipe_in = {skip_pipe_ff[0], skip};

   // state machine
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_RUN: begin
            if (take && func == tkdp_pkg::FUNC_FINISH) state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            if (acc_pipe_ff == '0) state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (status.list_empty || status.emit_last) state_in = ST_RUN;
         end
         default: state_in = ST_RUN;
      endcase
   end

   always_comb begin
      cmd          = '0;
      cmd.query_wr = take && func == tkdp_pkg::FUNC_QUERY;
      cmd.mac      = acc_pipe_ff[0];
      cmd.acc      = acc_pipe_ff[1];
      cmd.vec_end  = end_pipe_ff[1];
      cmd.vec_skip = skip_pipe_ff[1];
      cmd.emit     = (state_ff == ST_EMIT) && !status.list_empty;
      cmd.finish   = (state_ff == ST_EMIT) && (status.list_empty || status.emit_last);
   end

   assign strobe = (state_ff == ST_EMIT);
   assign found  = !status.list_empty;
   assign last   = status.list_empty || status.emit_last;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_RUN;
         qpos_ff      <= '0;
         epos_ff      <= '0;
         acc_pipe_ff  <= '0;
         end_pipe_ff  <= '0;
         skip_pipe_ff <= '0;
      end else begin
         state_ff     <= state_in;
         qpos_ff      <= qpos_in;
         epos_ff      <= epos_in;
         acc_pipe_ff  <= acc_pipe_in;
         end_pipe_ff  <= end_pipe_in;
         skip_pipe_ff <= skip_pipe_in;
      end
   end

   // no item taken while the list is being emitted
   assert property (@(posedge clock) disable iff (reset) strobe |-> busy)
      else $error("strobe while idle");
   // emission only starts once the mac pipeline is empty
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |-> acc_pipe_ff == '0)
      else $error("emit with pending vector");
   // a finish always makes the unit busy
   assert property (@(posedge clock) disable iff (reset)
      (take && func == tkdp_pkg::FUNC_FINISH) |=> busy)
      else $error("finish not started");

endmodule

>>> sv/top_k_dot_product_search_unit.sv
// ----------------------------------------------------------------------------
// top_k_dot_product_search_unit
// streaming top-k inner-product search over fixed-point vectors
// ----------------------------------------------------------------------------
// Query and vector elements are taken one per cycle while busy is low; each
// vector element goes through a three-stage read, multiply and accumulate
// pipeline, and a finished vector is shift-inserted into the sorted list in
// parallel. A finish item waits for that pipeline to drain and then puts out
// one result per cycle for every list entry, or a single not-found result;
// busy stays high throughout. Results cannot be stalled by the receiver.
// ----------------------------------------------------------------------------
module top_k_dot_product_search_unit #(
   parameter int MAX_RESULTS = tkdp_pkg::MAX_RESULTS_DEF,
   parameter int MAX_LENGTH  = tkdp_pkg::MAX_LENGTH_DEF,
   parameter int MAX_VECTORS = tkdp_pkg::MAX_VECTORS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [1:0]                          req_func,
   input  logic signed [tkdp_pkg::ELEM_W-1:0]  req_element,
   input  logic                                req_skip_vector,
   output logic                                rsp_strobe,
   output logic [tkdp_pkg::ID_W-1:0]           rsp_match_id,
   output logic signed [tkdp_pkg::SCORE_W-1:0] rsp_match_score,
   output logic                                rsp_found,
   output logic                                rsp_last_result,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [2:0]                          paddr,
   input  logic [31:0]                         pwdata,
   output logic [31:0]                         prdata,
   output logic                                pready
);

   logic [tkdp_pkg::COUNT_W-1:0]  count_ff, count_in;
   logic [tkdp_pkg::LEN_W-1:0]    len_ff, len_in;
   tkdp_pkg::cmd_type             cmd;
   tkdp_pkg::status_type          status;
   logic [$clog2(MAX_LENGTH)-1:0] query_addr, read_addr;
   logic                          read_ok;
   logic [$clog2(MAX_RESULTS+1)-1:0] keep;
   logic [tkdp_pkg::ID_W-1:0]     emit_id;
   logic [tkdp_pkg::SCORE_W-1:0]  emit_score;
   logic                          found;
   logic                          wr;

   // register port
   assign pready = 1'b1;
   assign wr     = psel && penable && pwrite;

   always_comb begin
      count_in = count_ff;
      len_in   = len_ff;
      if (wr && paddr[1:0] == 2'b00 && paddr[2] == tkdp_pkg::REG_COUNT) begin
         count_in = pwdata[tkdp_pkg::COUNT_W-1:0];
      end
      if (wr && paddr[1:0] == 2'b00 && paddr[2] == tkdp_pkg::REG_LENGTH) begin
         len_in = pwdata[tkdp_pkg::LEN_W-1:0];
      end
   end

   always_comb begin
      if (paddr[2] == tkdp_pkg::REG_COUNT) begin
         prdata = 32'(count_ff);
      end else begin
         prdata = 32'(len_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= tkdp_pkg::COUNT_RESET;
         len_ff   <= tkdp_pkg::LEN_RESET;
      end else begin
         count_ff <= count_in;
         len_ff   <= len_in;
      end
   end

   tkdp_ctrl #(.MAX_RESULTS(MAX_RESULTS), .MAX_LENGTH(MAX_LENGTH)) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .func       (req_func),
      .skip       (req_skip_vector),
      .count_reg  (count_ff),
      .len_reg    (len_ff),
      .status     (status),
      .cmd        (cmd),
      .query_addr (query_addr),
      .read_addr  (read_addr),
      .read_ok    (read_ok),
      .keep       (keep),
      .busy       (busy),
      .strobe     (rsp_strobe),
      .found      (found),
      .last       (rsp_last_result)
   );

   tkdp_datapath #(
      .MAX_RESULTS (MAX_RESULTS),
      .MAX_LENGTH  (MAX_LENGTH),
      .MAX_VECTORS (MAX_VECTORS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .elem       (req_element),
      .query_addr (query_addr),
      .read_addr  (read_addr),
      .read_ok    (read_ok),
      .keep       (keep),
      .status     (status),
      .emit_id    (emit_id),
      .emit_score (emit_score)
   );

   // not-found result reads as zero
   assign rsp_found       = found;
   assign rsp_match_id    = found ? emit_id : '0;
   assign rsp_match_score = found ? emit_score : '0;

endmodule

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the top-k dot-product search unit
// ----------------------------------------------------------------------------
// A short table of directed items, then random phases. Each phase writes
// both registers while the unit is idle. It then loads a query when none is
// ready or at random, streams vectors (some copied from the previous one to
// force equal scores, some marked skipped) and mostly ends with a finish. Every
// accepted item goes through a local predictor. Each result strobe is compared
// field by field with the oldest predicted match.
// ----------------------------------------------------------------------------
module testbench;

   localparam logic [1:0] FUNC_UNUSED = 2'd3;
   localparam logic [2:0] ADDR_COUNT  = 3'd0;
   localparam logic [2:0] ADDR_LENGTH = 3'd4;
   localparam int         CYCLE_LIMIT = 600000;
   localparam int         RANDOM_ITEMS = 410;

   typedef struct {
      logic [tkdp_pkg::ID_W-1:0]    id;
      logic [tkdp_pkg::SCORE_W-1:0] score;
      logic                         found;
      logic                         last;
   } match_type;

   typedef struct {
      bit          is_cfg;
      logic [2:0]  addr;
      logic [1:0]  func;
      logic [15:0] data;
      bit          skip;
      bit          typed;
      match_type   want;
   } row_type;

   logic clock = 0;
   logic reset;
   logic start;
   logic busy;
   logic [1:0] req_func;
   logic signed [tkdp_pkg::ELEM_W-1:0] req_element;
   logic req_skip_vector;
   logic rsp_strobe;
   logic [tkdp_pkg::ID_W-1:0] rsp_match_id;
   logic signed [tkdp_pkg::SCORE_W-1:0] rsp_match_score;
   logic rsp_found;
   logic rsp_last_result;
   logic psel, penable, pwrite;
   logic [2:0] paddr;
   logic [31:0] pwdata, prdata;
   logic pready;

   top_k_dot_product_search_unit DUT (
      .clock, .reset, .start, .busy, .req_func, .req_element, .req_skip_vector,
      .rsp_strobe, .rsp_match_id, .rsp_match_score, .rsp_found, .rsp_last_result,
      .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
   );

   always #6 clock = ~clock;

   // predictor state
   logic [4:0]  count_reg;
   logic [10:0] length_reg;
   logic signed [15:0] query_mem [tkdp_pkg::MAX_LENGTH_DEF];
   bit          query_valid [tkdp_pkg::MAX_LENGTH_DEF];
   int          query_pos, elem_pos, vector_id, list_fill;
   longint      dot_sum;
   longint      list_score [tkdp_pkg::MAX_RESULTS_DEF];
   int          list_id [tkdp_pkg::MAX_RESULTS_DEF];

   match_type pending_matches[$];
   match_type model_out[$];
   int     mismatches = 0;
   int     cycles = 0;
   bit     gaps_on = 1;

   function automatic int eff_length();
      if (length_reg == 0) return 1;
      if (length_reg > tkdp_pkg::MAX_LENGTH_DEF) return tkdp_pkg::MAX_LENGTH_DEF;
      return length_reg;
   endfunction

   function automatic int eff_count();
      if (count_reg == 0) return 1;
      if (count_reg > tkdp_pkg::MAX_RESULTS_DEF) return tkdp_pkg::MAX_RESULTS_DEF;
      return count_reg;
   endfunction

   function automatic bit query_ready();
      for (int i = 0; i < eff_length(); i++)
         if (!query_valid[i]) return 0;
      return 1;
   endfunction

   // sorted insert: higher score first, lower id on equal score
   function automatic void rank_insert(longint score, int id);
      int k, n, pos;
      k = eff_count();
      n = (list_fill < k) ? list_fill : k;
      pos = n;
      while (pos > 0 && (score > list_score[pos-1] ||
             (score == list_score[pos-1] && id < list_id[pos-1])))
         pos--;
      if (pos >= k) begin
         list_fill = n;
         return;
      end
      if (n == k) n = k - 1;
      for (int i = n; i > pos; i--) begin
         list_score[i] = list_score[i-1];
         list_id[i] = list_id[i-1];
      end
      list_score[pos] = score;
      list_id[pos] = id;
      list_fill = n + 1;
   endfunction

   // works out the matches one accepted item causes, into model_out
   function automatic void predict_search(logic [1:0] f, logic signed [15:0] e, logic s);
      int len, k, n;
      match_type m;
      len = eff_length();
      model_out.delete();
      case (f)
         tkdp_pkg::FUNC_QUERY: begin
            if (query_pos >= len) query_pos = 0;
            query_mem[query_pos] = e;
            query_valid[query_pos] = 1;
            query_pos++;
            if (query_pos >= len) query_pos = 0;
         end
         tkdp_pkg::FUNC_VECTOR: begin
            if (elem_pos < tkdp_pkg::MAX_LENGTH_DEF)
               dot_sum += longint'(query_mem[elem_pos]) * longint'(e);
            elem_pos++;
            if (elem_pos >= len) begin
               if (!s && vector_id < tkdp_pkg::MAX_VECTORS_DEF)
                  rank_insert(dot_sum, vector_id);
               if (vector_id < tkdp_pkg::MAX_VECTORS_DEF) vector_id++;
               elem_pos = 0;
               dot_sum = 0;
            end
         end
         tkdp_pkg::FUNC_FINISH: begin
            k = eff_count();
            n = (list_fill < k) ? list_fill : k;
            if (n == 0) begin
               m = '{id: '0, score: '0, found: 0, last: 1};
               model_out = {model_out, m};
            end
            for (int i = 0; i < n; i++) begin
               m.id = list_id[i][tkdp_pkg::ID_W-1:0];
               m.score = list_score[i][tkdp_pkg::SCORE_W-1:0];
               m.found = 1;
               m.last = (i + 1 == n);
               model_out = {model_out, m};
            end
            list_fill = 0;
            vector_id = 0;
            elem_pos = 0;
            dot_sum = 0;
            query_pos = 0;
         end
         default: ;
      endcase
   endfunction

   // result checking
   always @(posedge clock) begin
      match_type w;
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("== FAIL ==");
         $finish;
      end
      if (!reset && rsp_strobe) begin
         if (pending_matches.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result id %0d score %0d", rsp_match_id, rsp_match_score);
         end else begin
            w = pending_matches.pop_front();
            if (rsp_match_id !== w.id || rsp_match_score !== w.score ||
                rsp_found !== w.found || rsp_last_result !== w.last) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: exp id %0d score %0d found %0d last %0d, got %0d %0d %0d %0d",
                           w.id, $signed(w.score), w.found, w.last, rsp_match_id,
                           rsp_match_score, rsp_found, rsp_last_result);
            end
         end
      end
   end

   // one item over the start/busy handshake, with random gaps
   task automatic send_item(logic [1:0] f, logic [15:0] e, logic s, bit typed = 0,
                            match_type want = '{default: '0});
      if (gaps_on && $urandom_range(99) < 32) begin
         start <= 0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      start <= 1;
      req_func <= f;
      req_element <= e;
      req_skip_vector <= s;
      do @(posedge clock); while (busy);
      predict_search(f, e, s);
      if (typed) pending_matches = {pending_matches, want};
      else foreach (model_out[i]) pending_matches = {pending_matches, model_out[i]};
   endtask

   // pause until every expected match is in and the pipeline has drained
   task automatic drain();
      start <= 0;
      @(posedge clock);
      while (pending_matches.size() != 0 || busy) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic csr_write(logic [2:0] addr, logic [31:0] value);
      drain();
      psel <= 1;
      pwrite <= 1;
      penable <= 0;
      paddr <= addr;
      pwdata <= value;
      @(posedge clock);
      penable <= 1;
      @(posedge clock);
      psel <= 0;
      penable <= 0;
      if (addr == ADDR_COUNT) count_reg = value[4:0];
      else length_reg = value[10:0];
   endtask

   // directed items, expected match typed in where it is plain
   row_type directed [] = '{
      '{0, 0, tkdp_pkg::FUNC_FINISH, 16'h0000, 0, 1, '{0, 0, 0, 1}},
      '{1, ADDR_COUNT,  0, 16'd16, 0, 0, '{0, 0, 0, 0}},
      '{1, ADDR_LENGTH, 0, 16'd2,  0, 0, '{0, 0, 0, 0}},
      '{0, 0, tkdp_pkg::FUNC_QUERY,  16'h7FFF, 0, 0, '{0, 0, 0, 0}},
      '{0, 0, tkdp_pkg::FUNC_QUERY,  16'h8000, 0, 0, '{0, 0, 0, 0}},
      '{0, 0, tkdp_pkg::FUNC_VECTOR, 16'h8000, 0, 0, '{0, 0, 0, 0}},
      '{0, 0, tkdp_pkg::FUNC_VECTOR, 16'h7FFF, 0, 0, '{0, 0, 0, 0}},
      '{0, 0, tkdp_pkg::FUNC_VECTOR, 16'h7FFF, 0, 0, '{0, 0, 0, 0}},
      '{0, 0, tkdp_pkg::FUNC_VECTOR, 16'h8000, 0, 0, '{0, 0, 0, 0}},
      '{0, 0, tkdp_pkg::FUNC_VECTOR, 16'h8000, 0, 0, '{0, 0, 0, 0}},
      '{0, 0, tkdp_pkg::FUNC_VECTOR, 16'h8000, 1, 0, '{0, 0, 0, 0}},
      '{0, 0, tkdp_pkg::FUNC_VECTOR, 16'h0000, 0, 0, '{0, 0, 0, 0}},
      '{0, 0, tkdp_pkg::FUNC_VECTOR, 16'h0000, 0, 0, '{0, 0, 0, 0}},
      '{0, 0, FUNC_UNUSED, 16'hFFFF, 1, 0, '{0, 0, 0, 0}},
      '{0, 0, tkdp_pkg::FUNC_FINISH, 16'h0000, 0, 0, '{0, 0, 0, 0}},
      // zero registers act as one: equal scores, lower id kept
      '{1, ADDR_LENGTH, 0, 16'd0, 0, 0, '{0, 0, 0, 0}},
      '{1, ADDR_COUNT,  0, 16'd0, 0, 0, '{0, 0, 0, 0}},
      '{0, 0, tkdp_pkg::FUNC_QUERY,  16'h8000, 0, 0, '{0, 0, 0, 0}},
      '{0, 0, tkdp_pkg::FUNC_VECTOR, 16'h8000, 0, 0, '{0, 0, 0, 0}},
      '{0, 0, tkdp_pkg::FUNC_VECTOR, 16'h8000, 0, 0, '{0, 0, 0, 0}},
      '{0, 0, tkdp_pkg::FUNC_FINISH, 16'h0000, 0, 1, '{0, 42'd1073741824, 1, 1}},
      // length lowered part way through a vector
      '{1, ADDR_COUNT,  0, 16'd31, 0, 0, '{0, 0, 0, 0}},
      '{1, ADDR_LENGTH, 0, 16'd3,  0, 0, '{0, 0, 0, 0}},
      '{0, 0, tkdp_pkg::FUNC_QUERY,  16'd1, 0, 0, '{0, 0, 0, 0}},
      '{0, 0, tkdp_pkg::FUNC_QUERY,  16'd2, 0, 0, '{0, 0, 0, 0}},
      '{0, 0, tkdp_pkg::FUNC_QUERY,  16'd3, 0, 0, '{0, 0, 0, 0}},
      '{0, 0, tkdp_pkg::FUNC_VECTOR, 16'd5, 0, 0, '{0, 0, 0, 0}},
      '{0, 0, tkdp_pkg::FUNC_VECTOR, 16'd6, 0, 0, '{0, 0, 0, 0}},
      '{1, ADDR_LENGTH, 0, 16'd1, 0, 0, '{0, 0, 0, 0}},
      '{0, 0, tkdp_pkg::FUNC_VECTOR, 16'd7, 0, 0, '{0, 0, 0, 0}},
      '{0, 0, tkdp_pkg::FUNC_FINISH, 16'h0000, 0, 1, '{0, 42'd38, 1, 1}},
      // count lowered after insertions
      '{1, ADDR_COUNT,  0, 16'd4, 0, 0, '{0, 0, 0, 0}},
      '{0, 0, tkdp_pkg::FUNC_VECTOR, 16'd1, 0, 0, '{0, 0, 0, 0}},
      '{0, 0, tkdp_pkg::FUNC_VECTOR, 16'd3, 0, 0, '{0, 0, 0, 0}},
      '{0, 0, tkdp_pkg::FUNC_VECTOR, 16'd2, 0, 0, '{0, 0, 0, 0}},
      '{1, ADDR_COUNT,  0, 16'd2, 0, 0, '{0, 0, 0, 0}},
      '{0, 0, tkdp_pkg::FUNC_FINISH, 16'h0000, 0, 0, '{0, 0, 0, 0}}
   };

   // stimulus
   initial begin
      int sent, len, nvec, cut;
      logic [15:0] prev_vec [tkdp_pkg::MAX_LENGTH_DEF];
      bit have_prev, copy;
      logic [15:0] e;
      logic s;
      reset <= 1;
      start <= 0;
      req_func <= tkdp_pkg::FUNC_QUERY;
      req_element <= '0;
      req_skip_vector <= 0;
      psel <= 0;
      penable <= 0;
      pwrite <= 0;
      paddr <= '0;
      pwdata <= '0;
      count_reg = tkdp_pkg::COUNT_RESET;
      length_reg = tkdp_pkg::LEN_RESET;
      query_pos = 0;
      elem_pos = 0;
      vector_id = 0;
      list_fill = 0;
      dot_sum = 0;
      foreach (query_valid[i]) query_valid[i] = 0;
      repeat (2) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      foreach (directed[i]) begin
         if (directed[i].is_cfg) csr_write(directed[i].addr, directed[i].data);
         else send_item(directed[i].func, directed[i].data, directed[i].skip,
                        directed[i].typed, directed[i].want);
      end

      // random phases; phase 2 runs with no gaps
      sent = 0;
      have_prev = 0;
      for (int phase = 0; sent < RANDOM_ITEMS || phase < 5; phase++) begin
         gaps_on = (phase != 2);
         csr_write(ADDR_COUNT, (phase == 1) ? 32'd16 : 32'($urandom_range(0, 31)));
         if ($urandom_range(3) == 0) csr_write(ADDR_LENGTH, 32'($urandom_range(0, 3)));
         else csr_write(ADDR_LENGTH, 32'($urandom_range(1, 12)));
         len = eff_length();
         if (!query_ready() || $urandom_range(99) < 30)
            for (int j = 0; j < len; j++) begin
               send_item(tkdp_pkg::FUNC_QUERY, 16'($urandom), 1'($urandom));
               sent++;
            end
         nvec = (len > 100) ? 2 : $urandom_range(0, 18);
         for (int v = 0; v < nvec; v++) begin
            copy = have_prev && $urandom_range(99) < 20;
            for (int j = elem_pos; j < len; j++) begin
               if ($urandom_range(99) < 4) begin
                  // noise: unused func code
                  send_item(FUNC_UNUSED, 16'($urandom), 1'($urandom));
               end
               e = copy ? prev_vec[j] : 16'($urandom);
               s = (j == len - 1) ? ($urandom_range(99) < 20) : 1'($urandom);
               prev_vec[j] = e;
               send_item(tkdp_pkg::FUNC_VECTOR, e, s);
               sent++;
            end
            have_prev = 1;
         end
         // partial vector, left to the finish or to the next phase
         if ($urandom_range(99) < 25 && len > 1) begin
            cut = $urandom_range(1, len - 1);
            for (int j = elem_pos; j < cut; j++) begin
               send_item(tkdp_pkg::FUNC_VECTOR, 16'($urandom), 1'($urandom));
               sent++;
            end
         end
         if ($urandom_range(99) < 85) begin
            send_item(tkdp_pkg::FUNC_FINISH, 16'($urandom), 1'($urandom));
            sent++;
         end
      end
      send_item(tkdp_pkg::FUNC_FINISH, 16'h0000, 0);

      drain();
      repeat (20) @(posedge clock);
      if (mismatches == 0 && pending_matches.size() == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule

>>> sim.f
sv/tkdp_pkg.sv
sv/tkdp_ram.sv
sv/tkdp_datapath.sv
sv/tkdp_ctrl.sv
sv/top_k_dot_product_search_unit.sv
tb/testbench.sv
